[src/bhpq_pkg.sv]
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared widths, codes and types for the binary heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int KEY_W   = 16;
  localparam int TAG_W   = 8;
  localparam int ENTRY_W = 7;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

endpackage

`default_nettype wire

[src/bhpq_if.sv]
// ----------------------------------------------------------------------------
// bhpq_if
// Valid/ready channels for the heap command input and the status output.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhpq_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bhpq_pkg::KEY_W-1:0]   key;
  logic [bhpq_pkg::TAG_W-1:0]   tag;

  modport src (output valid, output kind, output key, output tag, input ready);
  modport snk (input valid, input kind, input key, input tag, output ready);
endinterface

interface bhpq_out_if;
  logic                         valid;
  logic                         ready;
  logic [bhpq_pkg::KEY_W-1:0]   top_key;
  logic [bhpq_pkg::TAG_W-1:0]   top_tag;
  logic [bhpq_pkg::ENTRY_W-1:0] entry_count;
  logic                         is_empty;
  bhpq_pkg::err_t               error_code;

  modport src (output valid, output top_key, output top_tag, output entry_count,
               output is_empty, output error_code, input ready);
  modport snk (input valid, input top_key, input top_tag, input entry_count,
               input is_empty, input error_code, output ready);
endinterface

`default_nettype wire

[src/bhpq_store.sv]
// ----------------------------------------------------------------------------
// bhpq_store
// Heap entry memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_store (
  input  wire                      clk,
  input  wire bhpq_pkg::mem_req_t  req,
  output bhpq_pkg::entry_t         rdata_a,
  output bhpq_pkg::entry_t         rdata_b
);

  bhpq_pkg::entry_t mem_r [bhpq_pkg::DEPTH];
  bhpq_pkg::entry_t rd_a_r;
  bhpq_pkg::entry_t rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_a_r <= mem_r[req.raddr_a];
    rd_b_r <= mem_r[req.raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

`default_nettype wire

[src/binary_heap_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_top
// Array heap priority queue with insert and pop, min-first or max-first.
// ----------------------------------------------------------------------------
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | kind, key, tag
//  out_ch  | out | valid/ready  | top_key, top_tag, entry_count, is_empty,
//          |     |              | error_code
//  cfg     | in  | cfg_we       | cfg_wdata (max_first)
//
//  Insert moves the new entry up one level per compare until a compare stops
//  it or it reaches the root; pop moves the last entry down from the root one
//  level per compare, toward the better child. Rejects and a pop to empty go
//  straight to S_OUT. The registered memory read and the single key comparator
//  set the pace. Reset clears the entry count and ordering bit, not the memory.
//  in_ch is ready only in idle; a beat waiting in the out_ch register holds
//  the next result, not the input.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue_top (
  input  wire     clk,
  input  wire     rst_n,
  bhpq_in_if.snk  in_ch,
  bhpq_out_if.src out_ch,
  input  wire     cfg_we,
  input  wire     cfg_wdata
);

  localparam int ADDR_W = bhpq_pkg::ADDR_W;
  localparam int CNT_W  = bhpq_pkg::CNT_W;
  localparam int IDX_W  = ADDR_W + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_DN_LAST = 9'b000001000,
    S_DN_RD   = 9'b000010000,
    S_DN_SEL  = 9'b000100000,
    S_DN_CMP  = 9'b001000000,
    S_FIN_WR  = 9'b010000000,
    S_OUT     = 9'b100000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [ADDR_W-1:0]             pos_r, pos_nxt;
  logic [ADDR_W-1:0]             best_idx_r, best_idx_nxt;
  bhpq_pkg::entry_t              cur_r, cur_nxt;
  bhpq_pkg::entry_t              best_r, best_nxt;
  bhpq_pkg::entry_t              root_r, root_nxt;
  bhpq_pkg::err_t                err_r, err_nxt;
  logic                          max_first_r;
  logic                          out_valid_r, out_valid_nxt;
  bhpq_pkg::entry_t              out_top_r, out_top_nxt;
  logic [bhpq_pkg::ENTRY_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                          out_empty_r, out_empty_nxt;
  bhpq_pkg::err_t                out_err_r, out_err_nxt;

  bhpq_pkg::mem_req_t            req;
  bhpq_pkg::entry_t              rdata_a;
  bhpq_pkg::entry_t              rdata_b;

  logic [bhpq_pkg::KEY_W-1:0]    cmp_a;
  logic [bhpq_pkg::KEY_W-1:0]    cmp_b;
  logic                          cmp_win;

  logic [ADDR_W-1:0]             parent;
  logic [IDX_W-1:0]              left;
  logic [IDX_W-1:0]              right;
  logic [IDX_W-1:0]              count_ext;
  logic [CNT_W-1:0]              count_dec;

  bhpq_store u_store (
    .clk     (clk),
    .req     (req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign parent    = ADDR_W'((pos_r - 1'b1) >> 1);
  assign left      = {1'b0, pos_r, 1'b1};
  assign right     = left + 1'b1;
  assign count_ext = IDX_W'(count_r);
  assign count_dec = count_r - 1'b1;

  // shared key comparator: true when cmp_a belongs nearer the root
  always_comb begin
    case (state_r)
      S_DN_SEL: begin
        cmp_a = rdata_b.key;
        cmp_b = rdata_a.key;
      end
      S_DN_CMP: begin
        cmp_a = best_r.key;
        cmp_b = cur_r.key;
      end
      default: begin
        cmp_a = cur_r.key;
        cmp_b = rdata_a.key;
      end
    endcase
    cmp_win = max_first_r ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    best_idx_nxt  = best_idx_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    root_nxt      = root_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_top_nxt   = out_top_r;
    out_cnt_nxt   = out_cnt_r;
    out_empty_nxt = out_empty_r;
    out_err_nxt   = out_err_r;
    req.we        = 1'b0;
    req.waddr     = pos_r;
    req.wdata     = cur_r;
    req.raddr_a   = parent;
    req.raddr_b   = ADDR_W'(right);

    case (state_r)
      S_IDLE: begin
        req.raddr_a = ADDR_W'(count_dec);
        if (in_ch.valid) begin
          err_nxt = bhpq_pkg::ERR_NONE;
          if (in_ch.kind == bhpq_pkg::KIND_INSERT) begin
            if (count_r >= CNT_W'(bhpq_pkg::DEPTH)) begin
              err_nxt   = bhpq_pkg::ERR_FULL;
              state_nxt = S_OUT;
            end else begin
              cur_nxt   = '{key: in_ch.key, tag: in_ch.tag};
              pos_nxt   = ADDR_W'(count_r);
              count_nxt = count_r + 1'b1;
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              err_nxt   = bhpq_pkg::ERR_EMPTY;
              state_nxt = S_OUT;
            end else begin
              count_nxt = count_dec;
              state_nxt = (count_dec == '0) ? S_OUT : S_DN_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        state_nxt = (pos_r == '0) ? S_FIN_WR : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (cmp_win) begin
          req.we    = 1'b1;
          req.wdata = rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_DN_LAST: begin
        cur_nxt   = rdata_a;
        pos_nxt   = '0;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        req.raddr_a = ADDR_W'(left);
        state_nxt   = (left >= count_ext) ? S_FIN_WR : S_DN_SEL;
      end
      S_DN_SEL: begin
        if ((right < count_ext) && cmp_win) begin
          best_nxt     = rdata_b;
          best_idx_nxt = ADDR_W'(right);
        end else begin
          best_nxt     = rdata_a;
          best_idx_nxt = ADDR_W'(left);
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (cmp_win) begin
          req.we    = 1'b1;
          req.wdata = best_r;
          pos_nxt   = best_idx_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        req.we    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = (count_r == '0) ? '0 : root_r;
          out_cnt_nxt   = bhpq_pkg::ENTRY_W'(count_r);
          out_empty_nxt = (count_r == '0);
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (req.we && (req.waddr == '0)) begin
      root_nxt = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      max_first_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_first_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    best_idx_r  <= best_idx_nxt;
    cur_r       <= cur_nxt;
    best_r      <= best_nxt;
    root_r      <= root_nxt;
    err_r       <= err_nxt;
    out_top_r   <= out_top_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.top_key     = out_top_r.key;
  assign out_ch.top_tag     = out_top_r.tag;
  assign out_ch.entry_count = out_cnt_r;
  assign out_ch.is_empty    = out_empty_r;
  assign out_ch.error_code  = out_err_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(bhpq_pkg::DEPTH))
    else $error("entry count above depth");

  a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.error_code == bhpq_pkg::ERR_FULL)
      |-> out_ch.entry_count == bhpq_pkg::ENTRY_W'(bhpq_pkg::DEPTH))
    else $error("full error with room left");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken again before result");

endmodule

`default_nettype wire
